// ----- src/fcd_pkg.sv -----
// Shared types and codes for the fixed-capacity deque.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic load;
  } cmd_t;

endpackage

// ----- src/fcd_ctrl.sv -----
// Controller of the fixed-capacity deque: request sequencing and the result valid flag.
// Depends on fcd_pkg.
`timescale 1ns / 1ps

module fcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output fcd_pkg::cmd_t cmd
);

  fcd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == fcd_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.exec = in_tvalid && (state_r == fcd_pkg::S_IDLE);
    cmd.load = (state_r == fcd_pkg::S_LOAD) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcd_pkg::S_IDLE: begin
        if (cmd.exec) begin
          state_nxt = fcd_pkg::S_LOAD;
        end
      end
      fcd_pkg::S_LOAD: begin
        if (cmd.load) begin
          state_nxt = fcd_pkg::S_IDLE;
        end
      end
      default: state_nxt = fcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/fcd_datapath.sv -----
// Datapath of the fixed-capacity deque: ring store, head and count, result register.
// Depends on fcd_pkg; driven by the commands of fcd_ctrl.
`timescale 1ns / 1ps

module fcd_datapath #(
  parameter int CAPACITY = 16,
  parameter int IW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int RES_W    = fcd_pkg::DATA_W + fcd_pkg::STAT_W + CW + 2,
  parameter int OUT_W    = ((RES_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fcd_pkg::cmd_t               cmd,
  input  logic [fcd_pkg::OP_W-1:0]    in_op,
  input  logic [fcd_pkg::DATA_W-1:0]  in_word,
  output logic [OUT_W-1:0]            out_data
);

  localparam int        DW      = fcd_pkg::DATA_W;
  localparam int        ST_LO   = DW;
  localparam int        CNT_LO  = DW + fcd_pkg::STAT_W;
  localparam int        EMP_BIT = CNT_LO + CW;
  localparam int        FUL_BIT = EMP_BIT + 1;
  localparam logic [CW:0]   CAP_S  = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

  logic [DW-1:0] mem [CAPACITY];

  logic [IW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [DW-1:0]    rd_data_r;
  logic             pop_ok_r;
  fcd_pkg::status_t status_r, status_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;

  fcd_pkg::op_t  op;
  logic          is_push, is_full, is_empty, push_ok, pop_ok;
  logic [CW-1:0] offset;
  logic [CW:0]   slot_sum;
  logic [IW-1:0] slot_wrap, head_dec, head_inc, wr_slot, rd_slot;

  assign op       = fcd_pkg::op_t'(in_op);
  assign is_push  = (op == fcd_pkg::OP_PUSH_FRONT) || (op == fcd_pkg::OP_PUSH_BACK);
  assign is_full  = (count_r == CAP_C);
  assign is_empty = (count_r == '0);
  assign push_ok  = is_push && !is_full;
  assign pop_ok   = !is_push && !is_empty;

  // Slot of the back word (count - 1) for a pop, or the next free slot for a push.
  // The offset stays below the capacity, so one compare and subtract wraps it.
  assign offset    = is_push ? count_r : (count_r - CW'(1));
  assign slot_sum  = (CW + 1)'(head_r) + (CW + 1)'(offset);
  assign slot_wrap = (slot_sum >= CAP_S) ? IW'(slot_sum - CAP_S) : IW'(slot_sum);
  assign head_dec  = (head_r == '0) ? LAST_I : (head_r - IW'(1));
  assign head_inc  = (head_r == LAST_I) ? '0 : (head_r + IW'(1));
  assign wr_slot   = (op == fcd_pkg::OP_PUSH_FRONT) ? head_dec : slot_wrap;
  assign rd_slot   = (op == fcd_pkg::OP_POP_FRONT) ? head_r : slot_wrap;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = fcd_pkg::ST_OK;
    if (is_push) begin
      if (is_full) begin
        status_nxt = fcd_pkg::ST_OVERFLOW;
      end else begin
        count_nxt = count_r + CW'(1);
        if (op == fcd_pkg::OP_PUSH_FRONT) begin
          head_nxt = head_dec;
        end
      end
    end else begin
      if (is_empty) begin
        status_nxt = fcd_pkg::ST_UNDERFLOW;
      end else begin
        count_nxt = count_r - CW'(1);
        if (op == fcd_pkg::OP_POP_FRONT) begin
          head_nxt = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[wr_slot] <= in_word;
    end
    if (cmd.exec && pop_ok) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok;
    end
  end

  // The count register already holds the value after the request here.
  always_comb begin
    out_data_nxt                        = '0;
    out_data_nxt[DW-1:0]                = pop_ok_r ? rd_data_r : '0;
    out_data_nxt[CNT_LO-1:ST_LO]        = status_r;
    out_data_nxt[EMP_BIT-1:CNT_LO]      = count_r;
    out_data_nxt[EMP_BIT]               = is_empty;
    out_data_nxt[FUL_BIT]               = is_full;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

// ----- src/fixed_capacity_deque.sv -----
// Fixed-capacity double-ended queue of signed 32-bit words: top level.
// Depends on fcd_pkg, fcd_ctrl and fcd_datapath.
`timescale 1ns / 1ps

// Each request on the in_ channel pushes or pops one word at either end of a ring store of
// CAPACITY words and returns exactly one result on the out_ channel: the popped word (zero
// for pushes and refused pops), a status of ok, overflow or underflow, the count after the
// request and empty and full flags. A push when full or a pop when empty leaves the contents
// unchanged. A request has an execute step, which updates the ring and issues the registered
// read of the store, and a load step, which loads the result register once that is free.
// No request is taken before the load step; the next is taken while the previous result
// waits on out_tready. No clearing pass follows reset: the block is ready at once.

module fixed_capacity_deque #(
  parameter int  CAPACITY = 16,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int OUT_W    = ((fcd_pkg::DATA_W + fcd_pkg::STAT_W + CW + 2 + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // data_value
  input  logic [fcd_pkg::DATA_W-1:0]  in_tdata,
  // operation
  input  logic [fcd_pkg::OP_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // popped_value, status, entry_count, is_empty, is_full, zero padding
  output logic [OUT_W-1:0]            out_tdata
);

  fcd_pkg::cmd_t cmd;

  fcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fcd_datapath #(
    .CAPACITY (CAPACITY),
    .IW       ($clog2(CAPACITY)),
    .CW       (CW),
    .RES_W    (fcd_pkg::DATA_W + fcd_pkg::STAT_W + CW + 2),
    .OUT_W    (OUT_W)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_op    (in_tuser),
    .in_word  (in_tdata),
    .out_data (out_tdata)
  );

endmodule

// ----- bench/fixed_capacity_deque_test.sv -----
// Self-checking bench for fixed_capacity_deque: directed and random request streams.
// Uses fcd_pkg for the operation and status codes; predicts every result internally.
`timescale 1ns / 1ps

module fixed_capacity_deque_test;

  localparam int CAP         = 16;
  localparam int CW          = 5;
  localparam int OUT_W       = 48;
  localparam int RANDOM_ITEMS = 970;
  localparam int HOLD_OFF_CYCLES = 60;

  typedef struct packed {
    logic [fcd_pkg::DATA_W-1:0] popped;
    fcd_pkg::status_t           status;
    logic [CW-1:0]              count;
    logic                       is_empty;
    logic                       is_full;
  } deque_result_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [fcd_pkg::DATA_W-1:0] in_tdata   = '0;
  logic [fcd_pkg::OP_W-1:0]   in_tuser   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_W-1:0]           out_tdata;

  // Predicted deque contents.
  logic [fcd_pkg::DATA_W-1:0] ring_words [CAP];
  logic [3:0]                 ring_head  = '0;
  logic [CW-1:0]              ring_count = '0;

  deque_result_t expected_results [$];
  int error_count = 0;

  // Sender and receiver pacing.
  bit tx_gaps    = 1'b0;
  bit rx_stalls  = 1'b0;
  int burst_left = 0;
  int hold_off_request = 0;
  int hold_off_seen    = 0;
  int hold_left        = 0;
  int rx_run_left      = 0;

  fixed_capacity_deque #(.CAPACITY(CAP)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // data_value
    .in_tuser   (in_tuser),   // operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // popped_value, status, entry_count, is_empty, is_full, padding
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("fixed_capacity_deque_test: errors");
    $finish;
  end

  function automatic deque_result_t apply_deque_op(input fcd_pkg::op_t op,
                                                   input logic [fcd_pkg::DATA_W-1:0] word);
    deque_result_t r;
    logic [3:0]    slot;
    r        = '0;
    r.status = fcd_pkg::ST_OK;
    case (op)
      fcd_pkg::OP_PUSH_FRONT, fcd_pkg::OP_PUSH_BACK: begin
        if (ring_count == CAP) begin
          r.status = fcd_pkg::ST_OVERFLOW;
        end else if (op == fcd_pkg::OP_PUSH_FRONT) begin
          ring_head             = ring_head - 4'd1;
          ring_words[ring_head] = word;
          ring_count            = ring_count + 1'b1;
        end else begin
          slot             = ring_head + ring_count[3:0];
          ring_words[slot] = word;
          ring_count       = ring_count + 1'b1;
        end
      end
      default: begin
        if (ring_count == 0) begin
          r.status = fcd_pkg::ST_UNDERFLOW;
        end else if (op == fcd_pkg::OP_POP_FRONT) begin
          r.popped   = ring_words[ring_head];
          ring_head  = ring_head + 4'd1;
          ring_count = ring_count - 1'b1;
        end else begin
          slot       = ring_head + ring_count[3:0] - 4'd1;
          r.popped   = ring_words[slot];
          ring_count = ring_count - 1'b1;
        end
      end
    endcase
    r.count    = ring_count;
    r.is_empty = (ring_count == 0);
    r.is_full  = (ring_count == CAP);
    return r;
  endfunction

  // Offers one request and records its prediction once it has been taken.
  task automatic send_request(input fcd_pkg::op_t op, input logic [fcd_pkg::DATA_W-1:0] word);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_deque_op(op, word));
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap        = $urandom_range(1, 6);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [fcd_pkg::DATA_W-1:0] random_word;
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: a long hold-off on request, otherwise always ready or a random stall pattern.
  always @(posedge clk) begin
    if (hold_off_seen != hold_off_request) begin
      hold_off_seen <= hold_off_request;
      hold_left     <= HOLD_OFF_CYCLES;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!rx_stalls) begin
      out_tready <= 1'b1;
    end else if (rx_run_left == 0) begin
      out_tready  <= !out_tready;
      rx_run_left <= out_tready ? $urandom_range(0, 5) : $urandom_range(0, 11);
    end else begin
      rx_run_left <= rx_run_left - 1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: out_tdata %h", out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.popped) begin
          $error("popped_value: expected %h, actual %h", want.popped, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[33:32] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[33:32]);
          error_count++;
        end
        if (out_tdata[38:34] !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, out_tdata[38:34]);
          error_count++;
        end
        if (out_tdata[39] !== want.is_empty) begin
          $error("is_empty: expected %b, actual %b", want.is_empty, out_tdata[39]);
          error_count++;
        end
        if (out_tdata[40] !== want.is_full) begin
          $error("is_full: expected %b, actual %b", want.is_full, out_tdata[40]);
          error_count++;
        end
        if (out_tdata[OUT_W-1:41] !== '0) begin
          $error("padding: expected 0, actual %h", out_tdata[OUT_W-1:41]);
          error_count++;
        end
      end
    end
  end

  // Pops on an empty deque, extreme words at both ends, and a single word in and out.
  task automatic test_empty_and_extremes;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_request(fcd_pkg::OP_POP_FRONT, $urandom());
    send_request(fcd_pkg::OP_POP_BACK, $urandom());
    send_request(fcd_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_request(fcd_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(fcd_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(fcd_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_request(fcd_pkg::OP_PUSH_BACK, 32'h5555_5555);
    send_request(fcd_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(fcd_pkg::OP_POP_BACK, $urandom());
    send_request(fcd_pkg::OP_POP_FRONT, $urandom());
    send_request(fcd_pkg::OP_POP_FRONT, $urandom());
    send_request(fcd_pkg::OP_POP_BACK, $urandom());
    send_request(fcd_pkg::OP_POP_BACK, $urandom());
    send_request(fcd_pkg::OP_POP_FRONT, $urandom());
    send_request(fcd_pkg::OP_POP_BACK, $urandom());
    send_request(fcd_pkg::OP_PUSH_BACK, 32'h0F0F_0F0F);
    send_request(fcd_pkg::OP_POP_FRONT, $urandom());
    send_request(fcd_pkg::OP_PUSH_FRONT, 32'hF0F0_F0F0);
    send_request(fcd_pkg::OP_POP_BACK, $urandom());
    drain_results();
  endtask

  // Fills the deque, tries both pushes while full, then empties it from alternating ends.
  task automatic test_full_and_overflow;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (CAP) begin
      send_request($urandom_range(0, 1) ? fcd_pkg::OP_PUSH_FRONT : fcd_pkg::OP_PUSH_BACK,
                   random_word());
    end
    send_request(fcd_pkg::OP_PUSH_FRONT, random_word());
    send_request(fcd_pkg::OP_PUSH_BACK, random_word());
    for (int i = 0; i < CAP; i++) begin
      send_request(i[0] ? fcd_pkg::OP_POP_BACK : fcd_pkg::OP_POP_FRONT, $urandom());
    end
    send_request(fcd_pkg::OP_POP_FRONT, $urandom());
    drain_results();
  endtask

  // The receiver holds off while requests keep coming, so the block must stall its input.
  task automatic test_input_stall;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_off_request++;
    repeat (12) send_request(fcd_pkg::op_t'($urandom_range(0, 3)), random_word());
    drain_results();
  endtask

  // Runs of push-heavy, pop-heavy and balanced requests, so that the deque keeps
  // swinging between full and empty with the head wrapping round the ring.
  task automatic test_random_walk;
    int sent;
    int run_len;
    int push_pct;
    fcd_pkg::op_t op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len   = $urandom_range(10, 40);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (run_len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? fcd_pkg::OP_PUSH_BACK : fcd_pkg::OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? fcd_pkg::OP_POP_BACK : fcd_pkg::OP_POP_FRONT;
        end
        send_request(op, random_word());
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_extremes();
    test_full_and_overflow();
    test_input_stall();
    test_random_walk();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("fixed_capacity_deque_test: clean");
    end else begin
      $display("fixed_capacity_deque_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/fcd_pkg.sv
src/fcd_ctrl.sv
src/fcd_datapath.sv
src/fixed_capacity_deque.sv
bench/fixed_capacity_deque_test.sv
